[rtl/json_string_unescape_utf8_macros.svh]
// Assertion macros shared by the JSON string unescaper RTL.
// Each macro expects i_clk and i_rst_n in the scope of its use.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/jsu_pkg.sv]
// Shared types and constants of the JSON string unescaper.
// No dependencies; used by the decoder, the top level and the testbench.
package jsu_pkg;

    localparam int unsigned JSU_QUEUE_DEPTH = 8;
    localparam int unsigned JSU_MAX_OUT     = 4;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESC    = 2'd1,
        PH_HEX    = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] hex_value;
        logic [2:0]  hex_count;
        logic        hex_stopped;
        logic [15:0] held_high;
    } t_state;

    typedef struct packed {
        logic [2:0]                   n;
        logic                         byte_valid;
        logic [JSU_MAX_OUT-1:0][7:0]  bytes;
    } t_dec;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } t_res;

endpackage

[rtl/jsu_if.sv]
// Valid/ready channel interfaces of the JSON string unescaper.
// Depends on nothing; one interface for the raw bytes, one for the results.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_last;

    modport source (output valid, output in_byte, output string_last, input ready);
    modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output string_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input string_end, output ready);
endinterface

[rtl/jsu_decode.sv]
// Combinational decoder: one string byte plus escape state to next state and
// up to four UTF-8 result bytes. Depends on jsu_pkg.
module jsu_decode (
    input  jsu_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output jsu_pkg::t_state o_state,
    output jsu_pkg::t_dec   o_dec
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_Q   = 8'h3F;

    function automatic logic [4:0] f_hex(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    t_state      ns;
    t_dec        dec;
    logic        fin;
    logic [15:0] code;
    logic [15:0] hv_n;
    logic [2:0]  cnt_n;
    logic [4:0]  hx;
    logic [20:0] full;

    always_comb begin
        ns        = i_state;
        dec       = '0;
        fin       = 1'b0;
        code      = 16'd0;
        hv_n      = i_state.hex_value;
        cnt_n     = i_state.hex_count + 3'd1;
        hx        = f_hex(i_byte);

        case (i_state.phase)
            PH_ESC: begin
                ns.phase = PH_NORMAL;
                dec.n    = 3'd1;
                case (i_byte)
                    CH_N: dec.bytes[0] = 8'h0A;
                    CH_R: dec.bytes[0] = 8'h0D;
                    CH_T: dec.bytes[0] = 8'h09;
                    CH_B: dec.bytes[0] = 8'h08;
                    CH_F: dec.bytes[0] = 8'h0C;
                    CH_U: begin
                        dec.n          = 3'd0;
                        ns.hex_value   = 16'd0;
                        ns.hex_count   = 3'd0;
                        ns.hex_stopped = 1'b0;
                        if (i_last) begin
                            fin = 1'b1;
                        end else begin
                            ns.phase = PH_HEX;
                        end
                    end
                    default: dec.bytes[0] = i_byte;
                endcase
            end
            PH_HEX: begin
                if (!i_state.hex_stopped && hx[4]) begin
                    hv_n = {i_state.hex_value[11:0], hx[3:0]};
                end else begin
                    ns.hex_stopped = 1'b1;
                end
                ns.hex_value = hv_n;
                ns.hex_count = cnt_n;
                if (cnt_n >= 3'd4 || i_last) begin
                    fin            = 1'b1;
                    code           = hv_n;
                    ns.phase       = PH_NORMAL;
                    ns.hex_value   = 16'd0;
                    ns.hex_count   = 3'd0;
                    ns.hex_stopped = 1'b0;
                end
            end
            default: begin
                ns.phase = PH_NORMAL;
                if (i_byte == CH_BSL) begin
                    if (i_last) begin
                        dec.n = 3'd1;
                    end else begin
                        ns.phase = PH_ESC;
                    end
                end else begin
                    dec.n        = 3'd1;
                    dec.bytes[0] = i_byte;
                end
            end
        endcase

        full = 21'h10000 + 21'({i_state.held_high[9:0], code[9:0]});

        if (i_last) begin
            ns.phase       = PH_NORMAL;
            ns.hex_value   = 16'd0;
            ns.hex_count   = 3'd0;
            ns.hex_stopped = 1'b0;
        end

        if (fin) begin
            if (i_state.held_high != 16'd0) begin
                ns.held_high = 16'd0;
                if (code >= 16'hDC00 && code <= 16'hDFFF) begin
                    dec.n        = 3'd4;
                    dec.bytes[0] = 8'hF0 | {5'd0, full[20:18]};
                    dec.bytes[1] = 8'h80 | {2'd0, full[17:12]};
                    dec.bytes[2] = 8'h80 | {2'd0, full[11:6]};
                    dec.bytes[3] = 8'h80 | {2'd0, full[5:0]};
                end else begin
                    dec.n        = 3'd1;
                    dec.bytes[0] = CH_Q;
                end
            end else if (code >= 16'hD800 && code <= 16'hDBFF) begin
                ns.held_high = code;
            end else if (code <= 16'h007F) begin
                dec.n        = 3'd1;
                dec.bytes[0] = code[7:0];
            end else if (code <= 16'h07FF) begin
                dec.n        = 3'd2;
                dec.bytes[0] = 8'hC0 | {3'd0, code[10:6]};
                dec.bytes[1] = 8'h80 | {2'd0, code[5:0]};
            end else begin
                dec.n        = 3'd3;
                dec.bytes[0] = 8'hE0 | {4'd0, code[15:12]};
                dec.bytes[1] = 8'h80 | {2'd0, code[11:6]};
                dec.bytes[2] = 8'h80 | {2'd0, code[5:0]};
            end
        end

        dec.byte_valid = (dec.n != 3'd0);
        if (!dec.byte_valid && i_last) begin
            dec.n = 3'd1;
        end
    end

    assign o_state = ns;
    assign o_dec   = dec;

endmodule

[rtl/json_string_unescape_utf8.sv]
// JSON string body unescaper with UTF-8 output: one string byte per transfer in,
// one decoded byte per transfer out. A byte goes through the input stage register and
// is decoded into the result queue. The input stage accepts a byte every cycle
// while the result queue (QUEUE_DEPTH entries, a power of two of at least four)
// has at least four free places; the output drains one byte per cycle while ready
// is high; an input decoding to k bytes (k = 0..4, one for a bare end marker) is k results.
// Depends on jsu_pkg, jsu_if, jsu_decode and the assertion macro header.
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 #(
    parameter int unsigned QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jsu_in_if.sink           i_in,
    jsu_out_if.source        o_out
);
    import jsu_pkg::*;

    localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(QUEUE_DEPTH - JSU_MAX_OUT);

    logic          r_stg_vld;
    logic [7:0]    r_stg_byte;
    logic          r_stg_last;
    t_state        r_state;
    t_state        n_state;
    t_dec          dec;
    t_res          r_queue [QUEUE_DEPTH];
    t_res          n_entry [JSU_MAX_OUT];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          stg_go;
    logic          pop;
    logic [2:0]    push_n;

    jsu_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_stg_byte),
        .i_last  (r_stg_last),
        .o_state (n_state),
        .o_dec   (dec)
    );

    assign stg_go      = r_stg_vld && (r_count <= FILL_MAX);
    assign i_in.ready  = !r_stg_vld || stg_go;
    assign push_n      = stg_go ? dec.n : 3'd0;
    assign o_out.valid = (r_count != '0);
    assign pop         = o_out.valid && o_out.ready;

    assign o_out.out_byte   = r_queue[r_rptr].out_byte;
    assign o_out.byte_valid = r_queue[r_rptr].byte_valid;
    assign o_out.run_last   = r_queue[r_rptr].run_last;
    assign o_out.string_end = r_queue[r_rptr].string_end;

    always_comb begin
        for (int k = 0; k < JSU_MAX_OUT; k++) begin
            n_entry[k].out_byte   = dec.bytes[k];
            n_entry[k].byte_valid = dec.byte_valid;
            n_entry[k].run_last   = (3'(k) == dec.n - 3'd1);
            n_entry[k].string_end = (3'(k) == dec.n - 3'd1) && r_stg_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_stg_byte <= i_in.in_byte;
            r_stg_last <= i_in.string_last;
        end
        if (stg_go) begin
            for (int k = 0; k < JSU_MAX_OUT; k++) begin
                if (3'(k) < dec.n) begin
                    r_queue[r_wptr + AW'(k)] <= n_entry[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
            r_state   <= '{phase: PH_NORMAL, default: '0};
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_count   <= '0;
        end else begin
            if (i_in.ready) begin
                r_stg_vld <= i_in.valid;
            end
            if (stg_go) begin
                r_state <= n_state;
                r_wptr  <= r_wptr + AW'(push_n);
            end
            if (pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            r_count <= r_count + CW'(push_n) - CW'(pop);
        end
    end

    `JSU_ASSERT_IMP(a_queue_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH), "result queue overflow")
    `JSU_ASSERT_IMP(a_marker_shape, o_out.valid && !o_out.byte_valid,
        o_out.run_last && o_out.string_end && o_out.out_byte == 8'd0, "bad end marker")
    `JSU_ASSERT_IMP(a_end_is_run_last, o_out.valid && o_out.string_end, o_out.run_last,
        "string end not on last result of transfer")
    `JSU_ASSERT_NXT(a_end_clears, stg_go && r_stg_last,
        r_state.phase == PH_NORMAL && r_state.hex_count == 3'd0,
        "escape state kept past string end")
    `JSU_ASSERT_IMP(a_held_range, 1'b1,
        r_state.held_high == 16'd0 ||
        (r_state.held_high >= 16'hD800 && r_state.held_high <= 16'hDBFF),
        "held value is not a high surrogate")

endmodule

[sim/tb_json_string_unescape_utf8.sv]
`timescale 1ns / 1ps
// Testbench for the JSON string unescaper: random and directed string bodies in,
// decoded UTF-8 bytes checked against an in-bench decoder of the same scheme.
// Depends on jsu_pkg, jsu_if and the json_string_unescape_utf8 top level.
module tb_json_string_unescape_utf8;

    localparam int          CLK_HALF    = 2;
    localparam int          RAND_ITEMS  = 280;
    localparam int          CALM_ITEMS  = 40;
    localparam int          DRAIN_CYC   = 20;
    localparam int          LIMIT_CYC   = 200000;
    localparam int          MAX_PRINTS  = 40;
    localparam logic [7:0]  CH_BSLASH   = 8'h5C;
    localparam logic [7:0]  CH_U        = 8'h75;
    localparam logic [7:0]  CH_QMARK    = 8'h3F;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         hold;
    } t_byte_item;

    logic clk;
    logic rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape_utf8 u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_byte_item      pending_bytes[$];
    jsu_pkg::t_res   expected_out[$];
    logic [7:0]      str_buf[$];
    logic [7:0]      decoded[$];

    int   errors;
    int   accepted_count;
    int   total_items;
    int   cycles;
    int   src_gap;
    int   sink_gap;
    bit   spacer_done;
    logic calm;

    // decoder state
    jsu_pkg::t_phase m_phase;
    logic [15:0]     m_hex;
    logic [2:0]      m_count;
    logic            m_stopped;
    logic [15:0]     m_held;

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    task automatic flag_error(input string msg);
        if (errors < MAX_PRINTS) $display("ERROR: %s", msg);
        errors++;
    endtask

    function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] d);
        d = 4'h0;
        if (b >= "0" && b <= "9") begin
            d = 4'(b - "0");
            return 1'b1;
        end
        if (b >= "a" && b <= "f") begin
            d = 4'(b - "a" + 10);
            return 1'b1;
        end
        if (b >= "A" && b <= "F") begin
            d = 4'(b - "A" + 10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_hex();
        m_hex     = 16'h0;
        m_count   = 3'd0;
        m_stopped = 1'b0;
    endtask

    task automatic encode_code_point(input logic [15:0] c);
        logic [20:0] full;
        if (m_held != 16'h0) begin
            if (c >= 16'hDC00 && c <= 16'hDFFF) begin
                full = 21'h10000 + ((m_held - 16'hD800) << 10) + (c - 16'hDC00);
                decoded.push_back({5'b11110, full[20:18]});
                decoded.push_back({2'b10, full[17:12]});
                decoded.push_back({2'b10, full[11:6]});
                decoded.push_back({2'b10, full[5:0]});
            end else begin
                decoded.push_back(CH_QMARK);
            end
            m_held = 16'h0;
        end else if (c >= 16'hD800 && c <= 16'hDBFF) begin
            m_held = c;
        end else if (c <= 16'h007F) begin
            decoded.push_back(c[7:0]);
        end else if (c <= 16'h07FF) begin
            decoded.push_back({3'b110, c[10:6]});
            decoded.push_back({2'b10, c[5:0]});
        end else begin
            decoded.push_back({4'b1110, c[15:12]});
            decoded.push_back({2'b10, c[11:6]});
            decoded.push_back({2'b10, c[5:0]});
        end
    endtask

    task automatic unescape_byte(input logic [7:0] b, input logic last);
        logic [3:0]    nib;
        jsu_pkg::t_res r;
        decoded.delete();
        case (m_phase)
            jsu_pkg::PH_ESC: begin
                m_phase = jsu_pkg::PH_NORMAL;
                case (b)
                    "n":     decoded.push_back(8'h0A);
                    "r":     decoded.push_back(8'h0D);
                    "t":     decoded.push_back(8'h09);
                    "b":     decoded.push_back(8'h08);
                    "f":     decoded.push_back(8'h0C);
                    CH_U: begin
                        clear_hex();
                        if (last) encode_code_point(16'h0);
                        else m_phase = jsu_pkg::PH_HEX;
                    end
                    default: decoded.push_back(b);
                endcase
            end
            jsu_pkg::PH_HEX: begin
                if (!m_stopped && hex_nibble(b, nib)) m_hex = {m_hex[11:0], nib};
                else m_stopped = 1'b1;
                m_count = m_count + 3'd1;
                if (m_count >= 3'd4 || last) begin
                    encode_code_point(m_hex);
                    m_phase = jsu_pkg::PH_NORMAL;
                    clear_hex();
                end
            end
            default: begin
                m_phase = jsu_pkg::PH_NORMAL;
                if (b == CH_BSLASH) begin
                    if (last) decoded.push_back(8'h00);
                    else m_phase = jsu_pkg::PH_ESC;
                end else begin
                    decoded.push_back(b);
                end
            end
        endcase
        if (last) begin
            m_phase = jsu_pkg::PH_NORMAL;
            clear_hex();
        end
        if (decoded.size() == 0) begin
            if (last) begin
                r.out_byte   = 8'h00;
                r.byte_valid = 1'b0;
                r.run_last   = 1'b1;
                r.string_end = 1'b1;
                expected_out.push_back(r);
            end
        end else begin
            foreach (decoded[k]) begin
                r.out_byte   = decoded[k];
                r.byte_valid = 1'b1;
                r.run_last   = (k == decoded.size() - 1);
                r.string_end = (k == decoded.size() - 1) && last;
                expected_out.push_back(r);
            end
        end
    endtask

    // stimulus building
    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'("0" + nib);
        if ($urandom_range(0, 1) == 0) return 8'("a" + nib - 10);
        return 8'("A" + nib - 10);
    endfunction

    task automatic put_hex_escape(input logic [15:0] code);
        str_buf.push_back(CH_BSLASH);
        str_buf.push_back(CH_U);
        str_buf.push_back(hex_char(code[15:12]));
        str_buf.push_back(hex_char(code[11:8]));
        str_buf.push_back(hex_char(code[7:4]));
        str_buf.push_back(hex_char(code[3:0]));
    endtask

    task automatic end_string(input bit hold);
        t_byte_item it;
        foreach (str_buf[i]) begin
            it.b    = str_buf[i];
            it.last = (i == str_buf.size() - 1);
            it.hold = hold && (i == 0);
            pending_bytes.push_back(it);
        end
        str_buf.delete();
    endtask

    task automatic put_random_token();
        int          kind;
        int          n;
        logic [7:0]  b;
        logic [15:0] code;
        logic [7:0]  simple_esc[8];
        simple_esc = '{"n", "r", "t", "b", "f", 8'h22, CH_BSLASH, "/"};
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
            str_buf.push_back(b);
        end else if (kind <= 4) begin
            str_buf.push_back(CH_BSLASH);
            n = $urandom_range(0, 8);
            if (n < 8) str_buf.push_back(simple_esc[n]);
            else str_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind <= 8) begin
            case ($urandom_range(0, 4))
                0:       code = 16'($urandom_range(16'h0000, 16'h007F));
                1:       code = 16'($urandom_range(16'h0080, 16'h07FF));
                2:       code = 16'($urandom_range(16'h0800, 16'hFFFF));
                3:       code = 16'($urandom_range(16'hD800, 16'hDBFF));
                default: code = 16'($urandom_range(16'hDC00, 16'hDFFF));
            endcase
            put_hex_escape(code);
            if (code >= 16'hD800 && code <= 16'hDBFF && $urandom_range(0, 9) < 6)
                put_hex_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else begin
            str_buf.push_back(CH_BSLASH);
            str_buf.push_back(CH_U);
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0) str_buf.push_back(hex_char(4'($urandom)));
                else str_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int target;
        int cut;
        int strings;
        in_if.valid       = 1'b0;
        in_if.in_byte     = 8'h00;
        in_if.string_last = 1'b0;
        out_if.ready      = 1'b0;
        rst_n             = 1'b0;
        errors            = 0;
        accepted_count    = 0;
        cycles            = 0;
        m_phase           = jsu_pkg::PH_NORMAL;
        clear_hex();
        m_held            = 16'h0;

        str_buf.push_back(8'h00);
        str_buf.push_back(8'hFF);
        end_string(1'b0);
        put_text("\\");
        end_string(1'b0);
        put_text("\\u");
        end_string(1'b0);
        put_text("\\n\\x\\t\\\\");
        end_string(1'b0);
        put_text("\\uD83D");
        end_string(1'b0);
        put_text("\\ude00\\uDC01");
        end_string(1'b0);
        put_text("\\uDBFFA");
        end_string(1'b0);
        put_text("\\u7g");
        end_string(1'b0);

        target  = pending_bytes.size() + RAND_ITEMS;
        strings = 0;
        while (pending_bytes.size() < target) begin
            repeat ($urandom_range(1, 4)) put_random_token();
            if ($urandom_range(0, 5) == 0 && str_buf.size() > 1) begin
                cut = $urandom_range(1, str_buf.size());
                while (str_buf.size() > cut) void'(str_buf.pop_back());
            end
            end_string(strings == 0 || strings == 25);
            strings++;
        end
        total_items = pending_bytes.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!(accepted_count == total_items && expected_out.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0) begin
            $display("tb_json_string_unescape_utf8 OK");
        end else begin
            $display("tb_json_string_unescape_utf8 NOT OK");
        end
        $finish;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYC) begin
            $display("tb_json_string_unescape_utf8 NOT OK");
            $finish;
        end
    end

    // driver
    always @(posedge clk) begin
        t_byte_item nxt;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            src_gap = 0;
            spacer_done = 1'b0;
            calm <= 1'b0;
        end else begin
            calm <= (pending_bytes.size() < CALM_ITEMS);
            if (in_if.valid && !in_if.ready) begin
                // hold until the transfer
            end else if (src_gap != 0) begin
                src_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (pending_bytes[0].hold && (!spacer_done || expected_out.size() != 0)) begin
                // drain all results before this string
                spacer_done = 1'b1;
                in_if.valid <= 1'b0;
            end else begin
                nxt = pending_bytes.pop_front();
                spacer_done = 1'b0;
                in_if.valid       <= 1'b1;
                in_if.in_byte     <= nxt.b;
                in_if.string_last <= nxt.last;
                if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 18);
            end
        end
    end

    // monitor: check output transfers, then predict from input transfers
    always @(posedge clk) begin
        jsu_pkg::t_res want;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_out.size() == 0) begin
                    flag_error($sformatf("unexpected result byte %02h", out_if.out_byte));
                end else begin
                    want = expected_out.pop_front();
                    if (out_if.out_byte !== want.out_byte)
                        flag_error($sformatf("out_byte %02h, want %02h",
                                             out_if.out_byte, want.out_byte));
                    if (out_if.byte_valid !== want.byte_valid)
                        flag_error($sformatf("byte_valid %b, want %b",
                                             out_if.byte_valid, want.byte_valid));
                    if (out_if.run_last !== want.run_last)
                        flag_error($sformatf("run_last %b, want %b",
                                             out_if.run_last, want.run_last));
                    if (out_if.string_end !== want.string_end)
                        flag_error($sformatf("string_end %b, want %b",
                                             out_if.string_end, want.string_end));
                end
            end
            if (in_if.valid && in_if.ready) begin
                unescape_byte(in_if.in_byte, in_if.string_last);
                accepted_count++;
            end
            if (calm) begin
                sink_gap = 0;
                out_if.ready <= 1'b1;
            end else if (sink_gap != 0) begin
                sink_gap--;
                out_if.ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(1, 18) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

endmodule

[json_string_unescape_utf8.f]
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_decode.sv
rtl/json_string_unescape_utf8.sv
sim/tb_json_string_unescape_utf8.sv
